// ===== hw/rtl/nsp_pkg.sv =====
package nsp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam int unsigned CMD_LEN  = 5;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_COMMA  = 3'd1,
        ST_ZERO_CMD  = 3'd2,
        ST_LF_NO_CR  = 3'd3,
        ST_ZERO_DATA = 3'd4,
        ST_TOO_LONG  = 3'd5,
        ST_BAD_END   = 3'd6
    } status_t;

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_CMD    = 8'b0000_0010,
        PH_COMMA  = 8'b0000_0100,
        PH_DATA   = 8'b0000_1000,
        PH_CK_HI  = 8'b0001_0000,
        PH_CK_LO  = 8'b0010_0000,
        PH_END_CR = 8'b0100_0000,
        PH_END_LF = 8'b1000_0000
    } phase_t;

    // fields listed msb first so the struct packs straight into tdata
    typedef struct packed {
        logic        checksum_match;
        logic [7:0]  computed_checksum;
        logic [7:0]  received_checksum;
        logic        checksum_present;
        logic [7:0]  field_count;
        logic [7:0]  data_length;
        logic [39:0] command_word;
        status_t     status;
        logic [7:0]  field_num;
        logic [7:0]  data_char;
    } result_t;

    typedef struct packed {
        kind_t   kind;
        result_t body;
    } word_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            h.value = b[3:0];
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.value = 4'(b[3:0] + 4'd9);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/nmea_sentence_parser.sv =====
// nmea sentence parser
// slave channel s_tvalid/s_tready/s_tdata carries one received byte per word.
// master channel m_tvalid/m_tready/m_tdata/m_tuser carries results: a data
// character with its field index, a field end for each comma in the data, or one
// sentence summary (status, command, lengths, checksums) at the end of a
// sentence or on an error. bytes outside a sentence give no word.
// a byte's result word is registered in the output register, or in the skid
// register while the receiver stalls; one byte per cycle is sustained while
// the skid register is empty.
// a two-entry output stage (output register plus skid register) parts the
// two sides: when the receiver stalls, bytes that give no word are still
// taken, one more result word goes into the skid register, and s_tready
// drops only while the skid register holds a word.
// reset clears the parser to hunting for '$' and empties the output stage.
// a sentence of MAX_SENTENCE bytes or more, '$' to LF, ends as too long.
module nmea_sentence_parser
    import nsp_pkg::*;
#(
    parameter int unsigned MAX_SENTENCE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_char, field_num, status, command_word, data_length, field_count,
    // checksum_present, received_checksum, computed_checksum, checksum_match
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser   // result_kind
);

    localparam int unsigned POS_W = $clog2(MAX_SENTENCE);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SENTENCE - 1);
    localparam logic [POS_W-1:0] POS_CMD_END = POS_W'(CMD_LEN + 1);

    phase_t          phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [39:0]     cmd_reg, cmd_next;
    logic [7:0]      xor_reg, xor_next;
    logic [3:0]      ck_hi_reg, ck_hi_next;
    logic            hi_ok_reg, hi_ok_next;
    logic [7:0]      ck_val_reg, ck_val_next;
    logic            ck_seen_reg, ck_seen_next;
    logic [7:0]      field_reg, field_next;
    logic [7:0]      count_reg, count_next;

    word_t           out_reg, skid_reg, res;
    logic            out_valid_reg, skid_valid_reg;
    logic            res_valid;
    logic            accept;
    logic            finish;
    status_t         fin_status;
    hex_t            hx;
    logic [7:0]      b;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign hx       = hex_decode(s_tdata);

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        cmd_next     = cmd_reg;
        xor_next     = xor_reg;
        ck_hi_next   = ck_hi_reg;
        hi_ok_next   = hi_ok_reg;
        ck_val_next  = ck_val_reg;
        ck_seen_next = ck_seen_reg;
        field_next   = field_reg;
        count_next   = count_reg;
        finish       = 1'b0;
        fin_status   = ST_OK;
        res_valid    = 1'b0;
        res          = '0;

        if (phase_reg == PH_HUNT)
        begin
            if (b == CH_DOLLAR)
            begin
                pos_next     = POS_W'(1);
                cmd_next     = '0;
                xor_next     = '0;
                ck_hi_next   = '0;
                hi_ok_next   = 1'b0;
                ck_val_next  = '0;
                ck_seen_next = 1'b0;
                field_next   = '0;
                count_next   = '0;
                phase_next   = PH_CMD;
            end
        end
        else if (pos_reg >= POS_LIMIT)
        begin
            finish     = 1'b1;
            fin_status = ST_TOO_LONG;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            case (phase_reg)
                PH_CMD:
                begin
                    if (b == 8'd0)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_ZERO_CMD;
                    end
                    else
                    begin
                        cmd_next = {cmd_reg[31:0], b};
                        xor_next = xor_reg ^ b;
                        if (pos_next >= POS_CMD_END)
                        begin
                            phase_next = PH_COMMA;
                        end
                    end
                end
                PH_COMMA:
                begin
                    if (b != CH_COMMA)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NO_COMMA;
                    end
                    else
                    begin
                        xor_next   = xor_reg ^ b;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (b == CH_CR)
                    begin
                        phase_next = PH_END_LF;
                    end
                    else if (b == CH_LF)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_LF_NO_CR;
                    end
                    else if (b == CH_STAR)
                    begin
                        phase_next = PH_CK_HI;
                    end
                    else if (b == 8'd0)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_ZERO_DATA;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ b;
                        count_next = count_reg + 1'b1;
                        res_valid = 1'b1;
                        res.body.field_num = field_reg;
                        if (b == CH_COMMA)
                        begin
                            res.kind   = KIND_FIELD;
                            field_next = field_reg + 1'b1;
                        end
                        else
                        begin
                            res.kind           = KIND_CHAR;
                            res.body.data_char = b;
                        end
                    end
                end
                PH_CK_HI:
                begin
                    hi_ok_next = hx.valid;
                    ck_hi_next = hx.value;
                    phase_next = PH_CK_LO;
                end
                PH_CK_LO:
                begin
                    if (hx.valid && hi_ok_reg)
                    begin
                        ck_val_next  = {ck_hi_reg, hx.value};
                        ck_seen_next = 1'b1;
                    end
                    phase_next = PH_END_CR;
                end
                PH_END_CR:
                begin
                    if (b != CH_CR)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_BAD_END;
                    end
                    else
                    begin
                        phase_next = PH_END_LF;
                    end
                end
                PH_END_LF:
                begin
                    finish     = 1'b1;
                    fin_status = (b == CH_LF) ? ST_OK : ST_BAD_END;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (finish)
        begin
            phase_next                  = PH_HUNT;
            res_valid                   = 1'b1;
            res.kind                    = KIND_END;
            res.body.data_char          = '0;
            res.body.field_num          = field_reg;
            res.body.status             = fin_status;
            res.body.command_word       = cmd_reg;
            res.body.data_length        = count_reg;
            res.body.field_count        = field_reg + 1'b1;
            res.body.checksum_present   = ck_seen_reg;
            res.body.received_checksum  = ck_seen_reg ? ck_val_reg : 8'd0;
            res.body.computed_checksum  = xor_reg;
            res.body.checksum_match     = ck_seen_reg && (ck_val_reg == xor_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            pos_reg     <= '0;
            cmd_reg     <= '0;
            xor_reg     <= '0;
            ck_hi_reg   <= '0;
            hi_ok_reg   <= 1'b0;
            ck_val_reg  <= '0;
            ck_seen_reg <= 1'b0;
            field_reg   <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            cmd_reg     <= cmd_next;
            xor_reg     <= xor_next;
            ck_hi_reg   <= ck_hi_next;
            hi_ok_reg   <= hi_ok_next;
            ck_val_reg  <= ck_val_next;
            ck_seen_reg <= ck_seen_next;
            field_reg   <= field_next;
            count_reg   <= count_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.body};
    assign m_tuser  = out_reg.kind;

endmodule

// ===== bench/tb_nmea_sentence_parser.sv =====
module tb_nmea_sentence_parser
    import nsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SENTENCE = 256;
    localparam int unsigned RANDOM_BYTES = 120;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_RUNS
    } rx_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    nmea_sentence_parser #(
        .MAX_SENTENCE(MAX_SENTENCE)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // parser state as seen by the prediction
    phase_t      cur_phase = PH_HUNT;
    logic [7:0]  char_pos;
    logic [39:0] cmd_bytes;
    logic [7:0]  xor_acc;
    logic [3:0]  ck_hi;
    logic        ck_hi_ok;
    logic [7:0]  ck_val;
    logic        ck_seen;
    logic [7:0]  field_no;
    logic [7:0]  data_len;

    word_t       parsed_words[$];
    int          fail_count = 0;

    bit          tx_bursty = 1'b0;
    int          burst_left = 0;
    rx_style_t   rx_style = RX_ALWAYS;
    int          hold_request = 0;
    int          hold_left = 0;
    int          run_left = 0;
    bit          run_ready = 1'b1;

    logic [7:0]  line_buf[$];
    word_t       want_word;
    result_t     got_body;

    function automatic void restart_sentence();
        char_pos = 8'd0;
        cmd_bytes = 40'd0;
        xor_acc = 8'd0;
        ck_hi = 4'd0;
        ck_hi_ok = 1'b0;
        ck_val = 8'd0;
        ck_seen = 1'b0;
        field_no = 8'd0;
        data_len = 8'd0;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - 8'h30)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic word_t sentence_summary(input status_t st);
        word_t w;
        w = '0;
        w.kind = KIND_END;
        w.body.field_num = field_no;
        w.body.status = st;
        w.body.command_word = cmd_bytes;
        w.body.data_length = data_len;
        w.body.field_count = field_no + 8'd1;
        w.body.checksum_present = ck_seen;
        w.body.received_checksum = ck_seen ? ck_val : 8'h00;
        w.body.computed_checksum = xor_acc;
        w.body.checksum_match = ck_seen && (ck_val == xor_acc);
        cur_phase = PH_HUNT;
        return w;
    endfunction

    // returns 1 when the byte produces a result word
    function automatic bit parse_byte(input logic [7:0] b, output word_t w);
        logic [4:0] h;
        w = '0;
        if (cur_phase == PH_HUNT)
        begin
            if (b == CH_DOLLAR)
            begin
                restart_sentence();
                char_pos = 8'd1;
                cur_phase = PH_CMD;
            end
            return 1'b0;
        end
        if (char_pos >= MAX_SENTENCE - 1)
        begin
            w = sentence_summary(ST_TOO_LONG);
            return 1'b1;
        end
        char_pos = char_pos + 8'd1;
        case (cur_phase)
            PH_CMD:
            begin
                if (b == 8'h00)
                begin
                    w = sentence_summary(ST_ZERO_CMD);
                    return 1'b1;
                end
                cmd_bytes = {cmd_bytes[31:0], b};
                xor_acc ^= b;
                if (char_pos >= CMD_LEN + 1)
                    cur_phase = PH_COMMA;
                return 1'b0;
            end
            PH_COMMA:
            begin
                if (b != CH_COMMA)
                begin
                    w = sentence_summary(ST_NO_COMMA);
                    return 1'b1;
                end
                xor_acc ^= b;
                cur_phase = PH_DATA;
                return 1'b0;
            end
            PH_DATA:
            begin
                if (b == CH_CR)
                begin
                    cur_phase = PH_END_LF;
                    return 1'b0;
                end
                if (b == CH_LF)
                begin
                    w = sentence_summary(ST_LF_NO_CR);
                    return 1'b1;
                end
                if (b == CH_STAR)
                begin
                    cur_phase = PH_CK_HI;
                    return 1'b0;
                end
                if (b == 8'h00)
                begin
                    w = sentence_summary(ST_ZERO_DATA);
                    return 1'b1;
                end
                xor_acc ^= b;
                data_len = data_len + 8'd1;
                w.body.field_num = field_no;
                if (b == CH_COMMA)
                begin
                    w.kind = KIND_FIELD;
                    field_no = field_no + 8'd1;
                end
                else
                begin
                    w.kind = KIND_CHAR;
                    w.body.data_char = b;
                end
                return 1'b1;
            end
            PH_CK_HI:
            begin
                h = hex_nibble(b);
                ck_hi_ok = h[4];
                ck_hi = h[3:0];
                cur_phase = PH_CK_LO;
                return 1'b0;
            end
            PH_CK_LO:
            begin
                h = hex_nibble(b);
                if (h[4] && ck_hi_ok)
                begin
                    ck_val = {ck_hi, h[3:0]};
                    ck_seen = 1'b1;
                end
                cur_phase = PH_END_CR;
                return 1'b0;
            end
            PH_END_CR:
            begin
                if (b != CH_CR)
                begin
                    w = sentence_summary(ST_BAD_END);
                    return 1'b1;
                end
                cur_phase = PH_END_LF;
                return 1'b0;
            end
            default:
            begin
                w = sentence_summary(b == CH_LF ? ST_OK : ST_BAD_END);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (parsed_words.size() == 0)
            begin
                $error("result word with none pending: kind %0d tdata %h", m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want_word = parsed_words.pop_front();
                got_body = result_t'(m_tdata[92:0]);
                check_field("result_kind", want_word.kind, m_tuser);
                check_field("data_char", want_word.body.data_char, got_body.data_char);
                check_field("field_num", want_word.body.field_num, got_body.field_num);
                check_field("status", want_word.body.status, got_body.status);
                check_field("command_word", want_word.body.command_word,
                            got_body.command_word);
                check_field("data_length", want_word.body.data_length, got_body.data_length);
                check_field("field_count", want_word.body.field_count, got_body.field_count);
                check_field("checksum_present", want_word.body.checksum_present,
                            got_body.checksum_present);
                check_field("received_checksum", want_word.body.received_checksum,
                            got_body.received_checksum);
                check_field("computed_checksum", want_word.body.computed_checksum,
                            got_body.computed_checksum);
                check_field("checksum_match", want_word.body.checksum_match,
                            got_body.checksum_match);
                check_field("tdata padding", 64'd0, m_tdata[95:93]);
            end
        end
    end

    // receiver: long hold-off on request, otherwise its own stall pattern
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS:
                    m_tready <= 1'b1;
                RX_RANDOM:
                    m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_ready = !run_ready;
                        run_left = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 5);
                    end
                    run_left--;
                    m_tready <= run_ready;
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        word_t w;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
                burst_left--;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (parse_byte(b, w))
            parsed_words.push_back(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_bytes();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
    endtask

    task automatic send_nmea(input string core, input bit lower);
        logic [7:0] sum;
        sum = 8'd0;
        for (int i = 0; i < core.len(); i++)
            sum ^= core[i];
        send_byte(CH_DOLLAR);
        send_text(core);
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4], lower));
        send_byte(hex_char(sum[3:0], lower));
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (parsed_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void build_sentence();
        logic [7:0] sum;
        logic [7:0] c;
        int n;
        line_buf.delete();
        sum = 8'd0;
        line_buf.push_back(CH_DOLLAR);
        for (int i = 0; i < CMD_LEN; i++)
        begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5a))
                                     : 8'($urandom_range(1, 255));
            line_buf.push_back(c);
            sum ^= c;
        end
        line_buf.push_back(CH_COMMA);
        sum ^= CH_COMMA;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 16);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                c = CH_COMMA;
            else
            begin
                c = 8'($urandom_range(1, 255));
                while (c == CH_CR || c == CH_LF || c == CH_STAR)
                    c = 8'($urandom_range(1, 255));
            end
            line_buf.push_back(c);
            sum ^= c;
        end
        case ($urandom_range(0, 9))
            0, 1:
                ;
            2:
            begin
                c = sum ^ 8'($urandom_range(1, 255));
                line_buf.push_back(CH_STAR);
                line_buf.push_back(hex_char(c[7:4], 1'b0));
                line_buf.push_back(hex_char(c[3:0], 1'b0));
            end
            3:
            begin
                line_buf.push_back(CH_STAR);
                line_buf.push_back(8'($urandom_range(0, 255)));
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                line_buf.push_back(CH_STAR);
                line_buf.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
                line_buf.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
            end
        endcase
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
    endfunction

    task automatic test_directed_cases();
        tx_bursty = 1'b1;
        rx_style = RX_RANDOM;
        // noise while hunting
        send_text("xx,*");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_nmea("GPGGA,123519,4807.038,N", 1'b0);
        send_nmea("GPRMC,,a,", 1'b1);
        send_text("$GPGSV,1,2*00");
        send_byte(CH_CR);
        send_byte(CH_LF);
        // checksum digits that are not hex
        send_text("$GPXYZ,A*G1");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("$GPXYZ,B*1g");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("$GPXYZ,");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("$GPXYZ;");
        send_text("$GP");
        send_byte(8'h00);
        // command bytes of any nonzero value
        send_byte(CH_DOLLAR);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'hff);
        send_byte(8'h01);
        send_byte(8'h80);
        send_text(",A");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("$GPAAA,12");
        send_byte(CH_LF);
        send_text("$GPAAA,1");
        send_byte(8'h00);
        send_text("$GPAAA,1*12X");
        send_text("$GPAAA,1");
        send_byte(CH_CR);
        send_text("X");
        // the breaking dollar is used up
        send_text("$GPAAA$GPBBB,1");
        send_byte(CH_CR);
        send_byte(CH_LF);
        // cr lf swallowed as checksum digits
        send_text("$GPAAA,*");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_nmea("GPAAA,$,,", 1'b0);
        drain();
    endtask

    task automatic test_length_limit();
        string core;
        tx_bursty = 1'b0;
        rx_style = RX_RUNS;
        // longest sentence that still fits, mostly commas
        core = "GPLEN,";
        for (int i = 0; i < MAX_SENTENCE - 13; i++)
            core = {core, ($urandom_range(0, 3) == 0) ? "7" : ","};
        send_nmea(core, 1'b0);
        // one byte too many: the closing lf hits the limit
        send_nmea({core, ","}, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_style = RX_ALWAYS;
        hold_request = 300;
        send_nmea("GPBPR,0123456789,ABCDEFGHIJ,abcdefghij,KLMNOPQRS", 1'b0);
        drain();
    endtask

    task automatic test_random_sentences();
        int sent;
        int pos;
        int count;
        sent = 0;
        count = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (count % 8 == 0)
            begin
                tx_bursty = ($urandom_range(0, 3) != 0);
                rx_style = rx_style_t'($urandom_range(0, 2));
            end
            count++;
            build_sentence();
            case ($urandom_range(0, 9))
                7:
                begin
                    pos = $urandom_range(1, line_buf.size() - 1);
                    line_buf[pos] = 8'($urandom_range(0, 255));
                end
                8:
                begin
                    pos = $urandom_range(1, line_buf.size() - 1);
                    while (line_buf.size() > pos)
                        void'(line_buf.pop_back());
                end
                9:
                begin
                    line_buf.delete();
                    repeat ($urandom_range(1, 6))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                    sent -= line_buf.size();
                end
                default:
                    ;
            endcase
            sent += line_buf.size();
            send_bytes();
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        restart_sentence();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed_cases();
        test_length_limit();
        test_backpressure();
        test_random_sentences();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && parsed_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
